// ----- src/kdlp_pkg.sv -----
// Shared types and constants for the key debounce and long press encoder.
package kdlp_pkg;

    localparam int unsigned LEVEL_BITS = 4;
    localparam int unsigned DELAY_W    = 16;
    localparam int unsigned TIME_W     = 32;
    localparam int unsigned KEY_NUM_W  = 2;
    localparam int unsigned TURN_W     = 16;
    localparam int unsigned CFG_DATA_W = 32;
    localparam int unsigned CFG_ADDR_W = 3;

    localparam logic signed [TURN_W-1:0] TURN_LIMIT = 16'sd32767;

    localparam logic [DELAY_W-1:0] DEBOUNCE_RESET   = 16'd20;
    localparam logic [DELAY_W-1:0] LONG_PRESS_RESET = 16'd1000;

    // Register select, taken from paddr[2]
    localparam logic REG_DEBOUNCE   = 1'b0;
    localparam logic REG_LONG_PRESS = 1'b1;

    typedef enum logic [2:0] {
        PH_UP       = 3'd0,
        PH_DEB_DOWN = 3'd1,
        PH_DOWN     = 3'd2,
        PH_LONG     = 3'd3,
        PH_DEB_UP   = 3'd4
    } phase_t;

    typedef enum logic [2:0] {
        EV_ROT_UP   = 3'd0,
        EV_ROT_DOWN = 3'd1,
        EV_KEY_DOWN = 3'd2,
        EV_KEY_LONG = 3'd3,
        EV_KEY_UP   = 3'd4
    } event_kind_t;

    typedef struct packed {
        logic        fire;
        event_kind_t kind;
    } key_evt_t;

endpackage

// ----- src/kdlp_lane.sv -----
// One key's debounce lane: phase and timestamp registers plus the step logic.
module kdlp_lane (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             step,
    input  logic                             pressed,
    input  logic [kdlp_pkg::TIME_W-1:0]      now_ms,
    input  logic [kdlp_pkg::DELAY_W-1:0]     debounce_ms,
    input  logic [kdlp_pkg::DELAY_W-1:0]     long_ms,
    output kdlp_pkg::key_evt_t               evt
);

    kdlp_pkg::phase_t                phase_reg;
    kdlp_pkg::phase_t                phase_next;
    logic [kdlp_pkg::TIME_W-1:0]     stamp_reg;
    logic [kdlp_pkg::TIME_W-1:0]     stamp_next;
    logic [kdlp_pkg::TIME_W-1:0]     elapsed;
    logic                            deb_over;
    logic                            long_over;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= kdlp_pkg::PH_UP;
        end else if (step) begin
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            stamp_reg <= stamp_next;
        end
    end

    // Elapsed time wraps modulo 2^32
    assign elapsed   = now_ms - stamp_reg;
    assign deb_over  = elapsed > {{(kdlp_pkg::TIME_W-kdlp_pkg::DELAY_W){1'b0}}, debounce_ms};
    assign long_over = elapsed > {{(kdlp_pkg::TIME_W-kdlp_pkg::DELAY_W){1'b0}}, long_ms};

    always_comb begin
        phase_next = phase_reg;
        stamp_next = stamp_reg;
        evt.fire   = 1'b0;
        evt.kind   = kdlp_pkg::EV_KEY_DOWN;
        unique case (phase_reg)
            kdlp_pkg::PH_DEB_DOWN: begin
                if (!pressed) begin
                    phase_next = kdlp_pkg::PH_UP;
                end else if (deb_over) begin
                    phase_next = kdlp_pkg::PH_DOWN;
                    evt.fire   = step;
                    evt.kind   = kdlp_pkg::EV_KEY_DOWN;
                end
            end
            kdlp_pkg::PH_DOWN: begin
                if (!pressed) begin
                    phase_next = kdlp_pkg::PH_DEB_UP;
                    stamp_next = now_ms;
                end else if (long_over) begin
                    phase_next = kdlp_pkg::PH_LONG;
                    evt.fire   = step;
                    evt.kind   = kdlp_pkg::EV_KEY_LONG;
                end
            end
            kdlp_pkg::PH_LONG: begin
                if (!pressed) begin
                    phase_next = kdlp_pkg::PH_DEB_UP;
                    stamp_next = now_ms;
                end
            end
            kdlp_pkg::PH_DEB_UP: begin
                if (pressed) begin
                    stamp_next = now_ms;
                end else if (deb_over) begin
                    phase_next = kdlp_pkg::PH_UP;
                    evt.fire   = step;
                    evt.kind   = kdlp_pkg::EV_KEY_UP;
                end
            end
            default: begin
                phase_next = kdlp_pkg::PH_UP;
                if (pressed) begin
                    stamp_next = now_ms;
                    phase_next = kdlp_pkg::PH_DEB_DOWN;
                end
            end
        endcase
    end

endmodule

// ----- src/kdlp_merge.sv -----
// Merge stage: collect the rotate and lane events of a poll and send them in order.
module kdlp_merge #(
    parameter int unsigned NUM_KEYS = 4
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  load,
    input  kdlp_pkg::key_evt_t [NUM_KEYS:0]       evts,
    output logic                                  busy,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic [2:0]                            m_event_kind,
    output logic [kdlp_pkg::KEY_NUM_W-1:0]        m_key_number,
    output logic                                  m_last_in_run
);

    localparam int unsigned NSlots = NUM_KEYS + 1;
    localparam int unsigned SlotW  = (NSlots > 1) ? $clog2(NSlots) : 1;

    logic [NSlots-1:0]                    pend_reg;
    logic [NSlots-1:0]                    pend_next;
    kdlp_pkg::event_kind_t [NSlots-1:0]   kind_reg;
    kdlp_pkg::event_kind_t [NSlots-1:0]   kind_next;
    logic [SlotW-1:0]                     idx_reg;
    logic [SlotW-1:0]                     idx_next;
    logic [SlotW-1:0]                     key_idx;
    logic                                 m_valid_reg;
    logic                                 m_valid_next;
    logic [2:0]                           kind_out_reg;
    logic [2:0]                           kind_out_next;
    logic [kdlp_pkg::KEY_NUM_W-1:0]       key_out_reg;
    logic [kdlp_pkg::KEY_NUM_W-1:0]       key_out_next;
    logic                                 last_out_reg;
    logic                                 last_out_next;
    logic                                 cur_pend;
    logic                                 out_free;
    logic                                 emit;
    logic                                 advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg    <= '0;
            idx_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            pend_reg    <= pend_next;
            idx_reg     <= idx_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        kind_reg     <= kind_next;
        kind_out_reg <= kind_out_next;
        key_out_reg  <= key_out_next;
        last_out_reg <= last_out_next;
    end

    assign cur_pend = pend_reg[idx_reg];
    assign out_free = !m_valid_reg || m_ready;
    assign emit     = cur_pend && out_free;
    // Skip empty slots, hold on a pending one until the output frees up; stop at the last slot
    assign advance  = (|pend_reg) && (!cur_pend || out_free)
                      && (idx_reg != SlotW'(NSlots - 1));
    assign key_idx  = idx_reg - SlotW'(1);

    always_comb begin
        pend_next     = pend_reg;
        kind_next     = kind_reg;
        idx_next      = idx_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        kind_out_next = kind_out_reg;
        key_out_next  = key_out_reg;
        last_out_next = last_out_reg;

        if (emit) begin
            pend_next[idx_reg] = 1'b0;
            m_valid_next       = 1'b1;
            kind_out_next      = kind_reg[idx_reg];
            key_out_next       = (idx_reg == '0) ? '0 : kdlp_pkg::KEY_NUM_W'(key_idx);
        end
        last_out_next = emit ? ~|pend_next : last_out_reg;
        if (advance) begin
            idx_next = idx_reg + SlotW'(1);
        end

        if (load) begin
            for (int i = 0; i < NSlots; i++) begin
                pend_next[i] = evts[i].fire;
                kind_next[i] = evts[i].kind;
            end
            idx_next = '0;
        end
    end

    assign busy          = |pend_reg;
    assign m_valid       = m_valid_reg;
    assign m_event_kind  = kind_out_reg;
    assign m_key_number  = key_out_reg;
    assign m_last_in_run = last_out_reg;

endmodule

// ----- src/key_debounce_long_press_encoder.sv -----
// Top level: encoder turn counter, per-key debounce lanes and event merge stage.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-----------------------------------------
//  s_      | in        | s_valid / s_ready    | req_type, enc_clk, enc_dt, key_levels, now_ms
//  m_      | out       | m_valid / m_ready    | event_kind, key_number, last_in_run
//  apb     | in/out    | psel/penable, pready | paddr, pwdata, prdata
//
// An encoder edge leaves s_ready high. A poll steps all key lanes in its accept
// cycle; the merge stage then walks the NUM_KEYS + 1 event slots one per cycle,
// holding on a pending slot while the output is stalled by m_ready, and stops after
// the last slot that holds an event. s_ready stays low until that event is in the
// output register, which a low m_ready delays; a poll that causes nothing frees the
// input at once.
// Reset (aresetn low, synchronous) puts every key in the up phase, clears the turn
// count and loads the delay registers with 20 ms and 1000 ms.
module key_debounce_long_press_encoder #(
    parameter int unsigned NUM_KEYS = 4
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,

    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic                                 s_req_type,
    input  logic                                 s_enc_clk,
    input  logic                                 s_enc_dt,
    input  logic [kdlp_pkg::LEVEL_BITS-1:0]      s_key_levels,
    input  logic [kdlp_pkg::TIME_W-1:0]          s_now_ms,

    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [2:0]                           m_event_kind,
    output logic [kdlp_pkg::KEY_NUM_W-1:0]       m_key_number,
    output logic                                 m_last_in_run,

    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [kdlp_pkg::CFG_ADDR_W-1:0]      paddr,
    input  logic [kdlp_pkg::CFG_DATA_W-1:0]      pwdata,
    output logic [kdlp_pkg::CFG_DATA_W-1:0]      prdata,
    output logic                                 pready
);

    logic                                      accept;
    logic                                      enc_step;
    logic                                      poll;
    logic                                      busy;
    logic signed [kdlp_pkg::TURN_W-1:0]        turn_reg;
    logic signed [kdlp_pkg::TURN_W-1:0]        turn_next;
    logic [kdlp_pkg::DELAY_W-1:0]              deb_reg;
    logic [kdlp_pkg::DELAY_W-1:0]              deb_next;
    logic [kdlp_pkg::DELAY_W-1:0]              long_reg;
    logic [kdlp_pkg::DELAY_W-1:0]              long_next;
    logic                                      cfg_write;
    kdlp_pkg::key_evt_t [NUM_KEYS:0]           evts;

    assign accept   = s_valid && s_ready;
    assign enc_step = accept && !s_req_type;
    assign poll     = accept && s_req_type;
    assign s_ready  = !busy;

    // ---------------- configuration port ----------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            deb_reg  <= kdlp_pkg::DEBOUNCE_RESET;
            long_reg <= kdlp_pkg::LONG_PRESS_RESET;
        end else begin
            deb_reg  <= deb_next;
            long_reg <= long_next;
        end
    end

    // Decode on the word select only; byte offset bits are ignored
    always_comb begin
        deb_next  = deb_reg;
        long_next = long_reg;
        prdata    = '0;
        unique case (paddr[2])
            kdlp_pkg::REG_DEBOUNCE: begin
                prdata = {{(kdlp_pkg::CFG_DATA_W-kdlp_pkg::DELAY_W){1'b0}}, deb_reg};
                if (cfg_write) begin
                    deb_next = pwdata[kdlp_pkg::DELAY_W-1:0];
                end
            end
            kdlp_pkg::REG_LONG_PRESS: begin
                prdata = {{(kdlp_pkg::CFG_DATA_W-kdlp_pkg::DELAY_W){1'b0}}, long_reg};
                if (cfg_write) begin
                    long_next = pwdata[kdlp_pkg::DELAY_W-1:0];
                end
            end
            default: begin
                prdata = '0;
            end
        endcase
    end

    // ---------------- encoder turn count ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            turn_reg <= '0;
        end else begin
            turn_reg <= turn_next;
        end
    end

    // Step down when the lines agree, up otherwise; saturate at +/- limit.
    // A poll reports the direction of a nonzero count and clears the count.
    always_comb begin
        turn_next = turn_reg;
        if (enc_step) begin
            if (s_enc_clk == s_enc_dt) begin
                if (turn_reg != -kdlp_pkg::TURN_LIMIT) begin
                    turn_next = turn_reg - 16'sd1;
                end
            end else if (turn_reg != kdlp_pkg::TURN_LIMIT) begin
                turn_next = turn_reg + 16'sd1;
            end
        end else if (poll) begin
            turn_next = '0;
        end
    end

    // Slot 0 carries the rotate event, ahead of every key
    assign evts[0].fire = turn_reg != '0;
    assign evts[0].kind = turn_reg[kdlp_pkg::TURN_W-1] ? kdlp_pkg::EV_ROT_DOWN
                                                        : kdlp_pkg::EV_ROT_UP;

    // ---------------- key lanes ----------------
    // All lanes step together on a poll; keys without a level bit read released.
    for (genvar k = 0; k < NUM_KEYS; k++) begin : g_lane
        logic pressed;
        if (k < kdlp_pkg::LEVEL_BITS) begin : g_bit
            assign pressed = !s_key_levels[k];
        end else begin : g_none
            assign pressed = 1'b0;
        end

        kdlp_lane u_lane (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .step        (poll),
            .pressed     (pressed),
            .now_ms      (s_now_ms),
            .debounce_ms (deb_reg),
            .long_ms     (long_reg),
            .evt         (evts[k+1])
        );
    end

    // ---------------- merge and output ----------------
    kdlp_merge #(
        .NUM_KEYS (NUM_KEYS)
    ) u_merge (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .load          (poll),
        .evts          (evts),
        .busy          (busy),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_event_kind  (m_event_kind),
        .m_key_number  (m_key_number),
        .m_last_in_run (m_last_in_run)
    );

endmodule

// ----- src/kdlp_checker.sv -----
// Port-level checks for the key debounce encoder, bound to the top level.
module kdlp_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_valid,
    input logic       s_ready,
    input logic       s_req_type,
    input logic       m_valid,
    input logic       m_ready,
    input logic [2:0] m_event_kind,
    input logic [1:0] m_key_number,
    input logic       m_last_in_run,
    input logic       pready
);

    // Hold a stalled result unchanged
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_event_kind)
                                && $stable(m_key_number) && $stable(m_last_in_run))
        else $error("stalled result changed");

    // Rotate events always carry key number zero
    a_rot_key: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_event_kind == kdlp_pkg::EV_ROT_UP
                    || m_event_kind == kdlp_pkg::EV_ROT_DOWN) |-> m_key_number == 2'd0)
        else $error("rotate event with nonzero key number");

    // An encoder edge never stalls the input
    a_enc_free: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && !s_req_type |=> s_ready)
        else $error("input stalled after encoder edge");

    // A rotate event is the first of its poll, so it is last only when alone
    a_rot_order: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_last_in_run |=> !(m_valid &&
            (m_event_kind == kdlp_pkg::EV_ROT_UP || m_event_kind == kdlp_pkg::EV_ROT_DOWN)))
        else $error("rotate event after a key event of the same poll");

    a_pready: assert property (@(posedge aclk) disable iff (!aresetn) pready)
        else $error("pready dropped");

endmodule

bind key_debounce_long_press_encoder kdlp_checker u_kdlp_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_valid       (s_valid),
    .s_ready       (s_ready),
    .s_req_type    (s_req_type),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_event_kind  (m_event_kind),
    .m_key_number  (m_key_number),
    .m_last_in_run (m_last_in_run),
    .pready        (pready)
);
